// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, checked on the rising edge of the clock
// and disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/sha1_pkg.sv -----
// ---------------------------------------------------------------------------
// sha1_pkg
// Types, constants and round functions for the SHA-1 digest engine.
// ---------------------------------------------------------------------------
package sha1_pkg;

   localparam int unsigned ROUNDS    = 80;
   localparam int unsigned WORDS     = 5;
   localparam logic [7:0]  PAD_BYTE  = 8'h80;
   localparam logic [5:0]  LEN_POS   = 6'd56;
   localparam logic [5:0]  BLOCK_END = 6'd63;
   localparam logic [2:0]  LAST_IDX  = 3'(WORDS - 1);
   localparam logic [6:0]  LAST_ROUND = 7'(ROUNDS - 1);

   localparam logic [4:0][31:0] H_INIT = {
      32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
   };

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_ROUND,
      ST_ADD,
      ST_OUT
   } sha1_state_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_present;
      logic       last;
   } req_item_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_word;
   } rsp_item_type;

   // Control from the sequencer to the message schedule.
   typedef struct packed {
      logic       push;       // place one byte
      logic [7:0] push_byte;
      logic       word_full;  // fourth byte of a word: shift it in
      logic       advance;    // compute next schedule word
   } sched_ctl_type;

   function automatic logic [31:0] round_k(input logic [6:0] t);
      logic [31:0] k;
      if (t < 7'd20)      k = 32'h5A827999;
      else if (t < 7'd40) k = 32'h6ED9EBA1;
      else if (t < 7'd60) k = 32'h8F1BBCDC;
      else                k = 32'hCA62C1D6;
      return k;
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] t, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d);
      logic [31:0] f;
      if (t < 7'd20)      f = (b & c) | (~b & d);
      else if (t < 7'd40) f = b ^ c ^ d;
      else if (t < 7'd60) f = (b & c) | (b & d) | (c & d);
      else                f = b ^ c ^ d;
      return f;
   endfunction

endpackage

// ----- hdl/sha1_sched.sv -----
// ---------------------------------------------------------------------------
// sha1_sched
// Message schedule: packs bytes big-endian into words and holds the last
// sixteen schedule words in a shift line; the oldest word feeds the round.
// ---------------------------------------------------------------------------
module sha1_sched
   import sha1_pkg::*;
(
   input  logic          clock,
   input  sched_ctl_type ctl,
   output logic [31:0]   w_t
);

   logic [23:0]       acc_ff, acc_in;
   logic [15:0][31:0] line_ff, line_in;
   logic [31:0]       full_word;
   logic [31:0]       mix;
   logic [31:0]       next_word;

   always_comb begin
      full_word = {acc_ff, ctl.push_byte};
      mix       = line_ff[13] ^ line_ff[8] ^ line_ff[2] ^ line_ff[0];
      next_word = {mix[30:0], mix[31]};
      acc_in    = acc_ff;
      line_in   = line_ff;
      if (ctl.push) begin
         acc_in = full_word[23:0];
         if (ctl.word_full) begin
            line_in = {full_word, line_ff[15:1]};
         end
      end else if (ctl.advance) begin
         line_in = {next_word, line_ff[15:1]};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      line_ff <= line_in;
   end

   assign w_t = line_ff[0];

endmodule

// ----- hdl/sha1_digest_engine.sv -----
// ---------------------------------------------------------------------------
// sha1_digest_engine
// SHA-1 engine: gathers message bytes into 64-byte blocks, runs 80 rounds
// per block on one round unit, pads on the final request and returns h0..h4.
// ---------------------------------------------------------------------------
//  channel | ports              | carries
//  --------+--------------------+------------------------------------------
//  request | req_valid/ready    | req_item: data_byte, byte_present, last
//  result  | rsp_valid/ready    | rsp_item: digest_word, word_index, last_word
//
//  A block-filling request adds 80 rounds and one chaining add on the single
//  round unit. A final request pads one byte per cycle (9 to 72 bytes, one or
//  two extra blocks), then holds five results, one per accepted word.
//  Requests stall through a block's rounds and chaining add, and from a final
//  request until the fifth word is taken. Reset is synchronous.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sha1_digest_engine
   import sha1_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_item_type req_item,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_item_type rsp_item
);

   sha1_state_type    state_ff, state_in;
   logic [5:0]        fill_ff, fill_in;
   logic [63:0]       bit_len_ff, bit_len_in;
   logic [4:0][31:0]  chain_ff, chain_in;
   logic [31:0]       a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [31:0]       a_in, b_in, c_in, d_in, e_in;
   logic [6:0]        round_ff, round_in;
   logic [2:0]        out_idx_ff, out_idx_in;
   logic              pad_pend_ff, pad_pend_in;
   logic              sent80_ff, sent80_in;
   logic              len_phase_ff, len_phase_in;
   logic              finish_ff, finish_in;

   sched_ctl_type     ctl;
   logic [31:0]       w_t;
   logic              req_fire;
   logic              rsp_fire;
   logic              is_len;
   logic              block_done;
   logic [31:0]       temp;

   sha1_sched u_sched (
      .clock (clock),
      .ctl   (ctl),
      .w_t   (w_t)
   );

   assign req_fire   = req_valid && req_ready;
   assign rsp_fire   = rsp_valid && rsp_ready;
   assign is_len     = len_phase_ff || (sent80_ff && (fill_ff == LEN_POS));
   assign block_done = ctl.push && (fill_ff == BLOCK_END);
   assign temp       = {a_ff[26:0], a_ff[31:27]} + round_f(round_ff, b_ff, c_ff, d_ff)
                       + e_ff + round_k(round_ff) + w_t;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_item.byte_present && (fill_ff == BLOCK_END)) state_in = ST_ROUND;
               else if (req_item.last)                             state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (fill_ff == BLOCK_END) state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (round_ff == LAST_ROUND) state_in = ST_ADD;
         end
         ST_ADD: begin
            if (finish_ff)        state_in = ST_OUT;
            else if (pad_pend_ff) state_in = ST_PAD;
            else                  state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_fire && (out_idx_ff == LAST_IDX)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      req_ready     = (state_ff == ST_IDLE);
      rsp_valid     = (state_ff == ST_OUT);
      ctl           = '0;
      fill_in       = fill_ff;
      bit_len_in    = bit_len_ff;
      chain_in      = chain_ff;
      round_in      = round_ff;
      out_idx_in    = out_idx_ff;
      pad_pend_in   = pad_pend_ff;
      sent80_in     = sent80_ff;
      len_phase_in  = len_phase_ff;
      finish_in     = finish_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff; d_in = d_ff; e_in = e_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_item.byte_present) begin
                  ctl.push      = 1'b1;
                  ctl.push_byte = req_item.data_byte;
                  bit_len_in    = bit_len_ff + 64'd8;
               end
               if (req_item.last) pad_pend_in = 1'b1;
            end
         end
         ST_PAD: begin
            ctl.push = 1'b1;
            if (!sent80_ff) begin
               ctl.push_byte = PAD_BYTE;
               sent80_in     = 1'b1;
            end else if (is_len) begin
               ctl.push_byte = bit_len_ff[{3'(~fill_ff[2:0]), 3'b000} +: 8];
               len_phase_in  = 1'b1;
               if (fill_ff == BLOCK_END) finish_in = 1'b1;
            end
         end
         ST_ROUND: begin
            ctl.advance = 1'b1;
            round_in    = round_ff + 7'd1;
            a_in = temp;
            b_in = a_ff;
            c_in = {b_ff[1:0], b_ff[31:2]};
            d_in = c_ff;
            e_in = d_ff;
         end
         ST_ADD: begin
            chain_in[0] = chain_ff[0] + a_ff;
            chain_in[1] = chain_ff[1] + b_ff;
            chain_in[2] = chain_ff[2] + c_ff;
            chain_in[3] = chain_ff[3] + d_ff;
            chain_in[4] = chain_ff[4] + e_ff;
         end
         ST_OUT: begin
            if (rsp_fire) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == LAST_IDX) begin
                  // Back to the initial state for the next message.
                  out_idx_in   = '0;
                  chain_in     = H_INIT;
                  bit_len_in   = '0;
                  pad_pend_in  = 1'b0;
                  sent80_in    = 1'b0;
                  len_phase_in = 1'b0;
                  finish_in    = 1'b0;
               end
            end
         end
         default: ;
      endcase

      if (ctl.push) begin
         ctl.word_full = (fill_ff[1:0] == 2'b11);
         fill_in       = fill_ff + 6'd1;
      end
      // Start a compression: load the working words from the chain.
      if (block_done) begin
         round_in = '0;
         a_in = chain_ff[0]; b_in = chain_ff[1]; c_in = chain_ff[2];
         d_in = chain_ff[3]; e_in = chain_ff[4];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         bit_len_ff   <= '0;
         chain_ff     <= H_INIT;
         round_ff     <= '0;
         out_idx_ff   <= '0;
         pad_pend_ff  <= 1'b0;
         sent80_ff    <= 1'b0;
         len_phase_ff <= 1'b0;
         finish_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         bit_len_ff   <= bit_len_in;
         chain_ff     <= chain_in;
         round_ff     <= round_in;
         out_idx_ff   <= out_idx_in;
         pad_pend_ff  <= pad_pend_in;
         sent80_ff    <= sent80_in;
         len_phase_ff <= len_phase_in;
         finish_ff    <= finish_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
      c_ff <= c_in;
      d_ff <= d_in;
      e_ff <= e_in;
   end

   assign rsp_item.digest_word = chain_ff[out_idx_ff];
   assign rsp_item.word_index  = out_idx_ff;
   assign rsp_item.last_word   = (out_idx_ff == LAST_IDX);

   `ASSERT_IMPL(a_no_overlap, clock, reset, req_ready, !rsp_valid, "request and result both open")
   `ASSERT_IMPL(a_round_range, clock, reset, state_ff == ST_ROUND, round_ff <= LAST_ROUND,
      "round counter out of range")
   `ASSERT_IMPL(a_out_aligned, clock, reset, rsp_valid, fill_ff == '0 && out_idx_ff <= LAST_IDX,
      "digest out with partial block")
   `ASSERT_NEXT(a_restart, clock, reset, rsp_fire && rsp_item.last_word,
      bit_len_ff == '0 && chain_ff == H_INIT && req_ready, "engine not restarted after digest")

endmodule

// ----- test/sha1_digest_engine_tb.sv -----
// ---------------------------------------------------------------------------
// sha1_digest_engine_tb
// Self-checking bench for the SHA-1 digest engine. A short table of requests
// covers the empty message, a byte on the final request, extreme byte values
// and requests that carry neither a byte nor an end mark. Random messages
// follow, with lengths that put the length field in the same block or push
// it into the next one. The digest words come from a local SHA-1 model,
// or a known table digest; both channels idle at random between requests.
// ---------------------------------------------------------------------------
module sha1_digest_engine_tb
   import sha1_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int DRAIN_CYCLES   = 300;
   localparam int RANDOM_ITEMS   = 100;
   localparam int MIN_MESSAGES   = 3;

   localparam logic [31:0] K_ROUND0 = 32'h5A827999;
   localparam logic [31:0] K_ROUND1 = 32'h6ED9EBA1;
   localparam logic [31:0] K_ROUND2 = 32'h8F1BBCDC;
   localparam logic [31:0] K_ROUND3 = 32'hCA62C1D6;

   localparam bit HAS_BYTE  = 1'b1;
   localparam bit NO_BYTE   = 1'b0;
   localparam bit ENDS      = 1'b1;
   localparam bit MORE      = 1'b0;
   localparam bit TYPED     = 1'b1;
   localparam bit PREDICTED = 1'b0;

   typedef struct packed {
      req_item_type item;
      logic         typed;
      logic [159:0] digest;
   } stim_row_type;

   localparam int DIRECTED_COUNT = 11;
   localparam stim_row_type DIRECTED_ROWS [DIRECTED_COUNT] = '{
      {8'h5A, NO_BYTE,  MORE, PREDICTED, 160'h0},
      // empty message
      {8'h00, NO_BYTE,  ENDS, TYPED,
       160'hda39a3ee_5e6b4b0d_3255bfef_95601890_afd80709},
      // "abc" with the final byte on the end request
      {8'h61, HAS_BYTE, MORE, PREDICTED, 160'h0},
      {8'h62, HAS_BYTE, MORE, PREDICTED, 160'h0},
      {8'h63, HAS_BYTE, ENDS, TYPED,
       160'ha9993e36_4706816a_ba3e2571_7850c26c_9cd0d89d},
      {8'hFF, HAS_BYTE, MORE, PREDICTED, 160'h0},
      {8'h00, HAS_BYTE, MORE, PREDICTED, 160'h0},
      {8'hA5, NO_BYTE,  MORE, PREDICTED, 160'h0},
      {8'h3C, NO_BYTE,  ENDS, PREDICTED, 160'h0},
      {8'hFF, HAS_BYTE, ENDS, PREDICTED, 160'h0},
      {8'h00, HAS_BYTE, ENDS, PREDICTED, 160'h0}
   };

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_item  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_item;

   rsp_item_type digest_queue [$];
   int           mismatch_count = 0;

   // local hash state
   logic [31:0] hash_h [5];
   logic [31:0] hash_blk [16];
   int unsigned hash_fill;
   logic [63:0] hash_bits;

   sha1_digest_engine u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [31:0] rol32(input logic [31:0] v, input int s);
      return (v << s) | (v >> (32 - s));
   endfunction

   function automatic void hash_reset();
      for (int i = 0; i < 5; i++) hash_h[i] = H_INIT[i];
      for (int i = 0; i < 16; i++) hash_blk[i] = '0;
      hash_fill = 0;
      hash_bits = '0;
   endfunction

   function automatic void hash_compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, k, t;
      for (int i = 0; i < 16; i++) w[i] = hash_blk[i];
      for (int i = 16; i < 80; i++)
         w[i] = rol32(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
      a = hash_h[0]; b = hash_h[1]; c = hash_h[2]; d = hash_h[3]; e = hash_h[4];
      for (int i = 0; i < 80; i++) begin
         if (i < 20) begin
            f = (b & c) | (~b & d);          k = K_ROUND0;
         end else if (i < 40) begin
            f = b ^ c ^ d;                   k = K_ROUND1;
         end else if (i < 60) begin
            f = (b & c) | (b & d) | (c & d); k = K_ROUND2;
         end else begin
            f = b ^ c ^ d;                   k = K_ROUND3;
         end
         t = rol32(a, 5) + f + e + k + w[i];
         e = d; d = c; c = rol32(b, 30); b = a; a = t;
      end
      hash_h[0] += a; hash_h[1] += b; hash_h[2] += c; hash_h[3] += d; hash_h[4] += e;
   endfunction

   // pack big-endian, compress on a full block
   function automatic void hash_absorb(input logic [7:0] value);
      int unsigned word;
      int unsigned shift;
      word  = hash_fill >> 2;
      shift = (3 - (hash_fill & 3)) * 8;
      if ((hash_fill & 3) == 0) hash_blk[word] = 32'(value) << shift;
      else hash_blk[word] |= 32'(value) << shift;
      hash_fill++;
      if (hash_fill == 64) begin
         hash_compress();
         hash_fill = 0;
      end
   endfunction

   // returns 1 when the request closes a message; words holds h0..h4
   function automatic bit hash_step(input req_item_type it,
                                    output logic [4:0][31:0] words);
      logic [63:0] msg_len;
      words = '0;
      if (it.byte_present) begin
         hash_absorb(it.data_byte);
         hash_bits += 64'd8;
      end
      if (!it.last) return 1'b0;
      msg_len = hash_bits;
      hash_absorb(PAD_BYTE);
      while (hash_fill != LEN_POS) hash_absorb(8'h00);
      for (int i = 7; i >= 0; i--) hash_absorb(msg_len[8*i +: 8]);
      for (int i = 0; i < 5; i++) words[i] = hash_h[i];
      hash_reset();
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("ERROR %0t: %s: got %h, expected %h", $time, what, got, want);
      mismatch_count++;
   endtask

   task automatic send_request(input req_item_type item, input bit typed,
                               input logic [159:0] typed_digest, input bit burst);
      int               gap;
      logic [4:0][31:0] words;
      rsp_item_type     want;
      gap = burst ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_item  <= item;
      do @(posedge clock); while (req_ready !== 1'b1);
      if (hash_step(item, words)) begin
         for (int i = 0; i < 5; i++) begin
            want.digest_word = typed ? typed_digest[159 - 32*i -: 32] : words[i];
            want.word_index  = 3'(i);
            want.last_word   = (3'(i) == LAST_IDX);
            digest_queue.push_back(want);
         end
      end
   endtask

   // result side: random stall before each word, check against oldest entry
   initial begin : result_side
      rsp_item_type want;
      int           gap;
      bit           burst;
      int           taken;
      taken = 0;
      burst = 1'b0;
      wait (reset === 1'b0);
      forever begin
         if (taken % 5 == 0) burst = ($urandom_range(0, 3) == 0);
         gap = burst ? 0 : $urandom_range(0, 13);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
         taken++;
         if (digest_queue.size() == 0) begin
            report_mismatch("digest word with nothing pending", rsp_item.digest_word, '0);
         end else begin
            want = digest_queue.pop_front();
            if (rsp_item.digest_word !== want.digest_word)
               report_mismatch("digest_word", rsp_item.digest_word, want.digest_word);
            if (rsp_item.word_index !== want.word_index)
               report_mismatch("word_index", 32'(rsp_item.word_index), 32'(want.word_index));
            if (rsp_item.last_word !== want.last_word)
               report_mismatch("last_word", 32'(rsp_item.last_word), 32'(want.last_word));
         end
      end
   end

   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset === 1'b1 || (req_valid === 1'b1 && req_ready === 1'b1) ||
             (rsp_valid === 1'b1 && rsp_ready === 1'b1))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
            $display("sha1_digest_engine_tb: FAIL");
            $finish;
         end
      end
   end

   initial begin : stimulus
      req_item_type item;
      int           msg_len;
      int           pick;
      int           item_total;
      int           msg_total;
      bit           burst;
      bit           tail_byte;
      item_total = 0;
      msg_total  = 0;
      hash_reset();
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < DIRECTED_COUNT; r++)
         send_request(DIRECTED_ROWS[r].item, DIRECTED_ROWS[r].typed,
                      DIRECTED_ROWS[r].digest, (r % 3) == 0);

      while (item_total < RANDOM_ITEMS || msg_total < MIN_MESSAGES) begin
         // first two messages straddle the length-field boundary
         pick = $urandom_range(0, 19);
         if (msg_total == 0)      msg_len = 55;
         else if (msg_total == 1) msg_len = 56;
         else if (pick < 14)      msg_len = $urandom_range(0, 12);
         else if (pick < 18)      msg_len = $urandom_range(53, 65);
         else if (pick < 19)      msg_len = $urandom_range(119, 130);
         else                     msg_len = $urandom_range(0, 1);
         burst     = ($urandom_range(0, 3) == 0);
         tail_byte = (msg_len > 0) && ($urandom_range(0, 1) == 1);
         for (int n = 0; n < msg_len - int'(tail_byte); n++) begin
            if ($urandom_range(0, 9) == 0) begin
               item.data_byte    = 8'($urandom);
               item.byte_present = NO_BYTE;
               item.last         = MORE;
               send_request(item, PREDICTED, '0, burst);
            end
            item.data_byte    = 8'($urandom);
            item.byte_present = HAS_BYTE;
            item.last         = MORE;
            send_request(item, PREDICTED, '0, burst);
            item_total++;
         end
         item.data_byte    = 8'($urandom);
         item.byte_present = tail_byte;
         item.last         = ENDS;
         send_request(item, PREDICTED, '0, burst);
         item_total++;
         msg_total++;
      end
      req_valid <= 1'b0;

      while (digest_queue.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("sha1_digest_engine_tb: PASS");
      else
         $display("sha1_digest_engine_tb: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/sha1_pkg.sv
hdl/sha1_sched.sv
hdl/sha1_digest_engine.sv
test/sha1_digest_engine_tb.sv
